>>> src/kruskal_union_find_edge_filter_macros.svh
// Assertion macros for the Kruskal edge filter.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_MACROS_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define KUFEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KUFEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define KUFEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KUFEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/kufef_pkg.sv
// Shared constants and types for the Kruskal union-find edge filter.
package kufef_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int NODE_W        = 10;
    localparam int WEIGHT_W      = 32;
    localparam int SUM_W         = 30;
    localparam int CFG_W         = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
    localparam logic [SUM_W-1:0] MODULUS   = 30'd1000000007;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIND_HALF,
        S_MERGE,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic job_clear;
        logic clr_step;
        logic load;
        logic latch_size_a;
        logic chk;
        logic root_a;
        logic half;
        logic merge;
        logic report;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic index_err;
        logic is_root;
    } t_dp_status;

endpackage

>>> src/kruskal_union_find_edge_filter.sv
// After start is taken, each endpoint in turn is walked to its root on the parent memory,
// halving the path; then the two roots are merged and o_done pulses from a register set in the
// report state. An edge with an endpoint out of range skips both walks. No new edge is taken while busy is high.
// After reset and after each node_count write, a clearing pass over every table entry
// rewrites both tables while busy is high; results cannot be stalled.
`include "kruskal_union_find_edge_filter_macros.svh"

module kruskal_union_find_edge_filter #(
    parameter int MAX_NODES = kufef_pkg::DEF_MAX_NODES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kufef_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [kufef_pkg::NODE_W-1:0]    i_node_a,
    input  logic [kufef_pkg::NODE_W-1:0]    i_node_b,
    input  logic [kufef_pkg::WEIGHT_W-1:0]  i_edge_weight,
    output logic                            o_done,
    output logic                            o_accepted,
    output logic [kufef_pkg::SUM_W-1:0]     o_total_mod,
    output logic [kufef_pkg::SUM_W-1:0]     o_doubled_total_mod,
    output logic [kufef_pkg::CFG_W-1:0]     o_components_left,
    output logic                            o_all_connected,
    output logic                            o_index_error
);
    import kufef_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    kufef_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cfg_we (i_cfg_we),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    kufef_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_data          (i_cfg_data),
        .i_node_a            (i_node_a),
        .i_node_b            (i_node_b),
        .i_edge_weight       (i_edge_weight),
        .o_done              (o_done),
        .o_accepted          (o_accepted),
        .o_total_mod         (o_total_mod),
        .o_doubled_total_mod (o_doubled_total_mod),
        .o_components_left   (o_components_left),
        .o_all_connected     (o_all_connected),
        .o_index_error       (o_index_error)
    );

    `KUFEF_ASSERT_NXT(a_item_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `KUFEF_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `KUFEF_ASSERT_IMP(a_totals_reduced, i_clk, i_rst_n, o_done, (o_total_mod < MODULUS) && (o_doubled_total_mod < MODULUS))
    `KUFEF_ASSERT_IMP(a_err_not_merged, i_clk, i_rst_n, o_done && o_index_error, !o_accepted)
    `KUFEF_ASSERT_IMP(a_connected_flag, i_clk, i_rst_n, o_done, o_all_connected == (o_components_left == 11'd1))

endmodule

>>> src/kufef_ctrl.sv
// Sequencing state machine for the union-find edge filter.
module kufef_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_cfg_we,
    input  kufef_pkg::t_dp_status i_status,
    output kufef_pkg::t_dp_cmd    o_cmd,
    output logic                  busy
);
    import kufef_pkg::*;

    t_state r_state, n_state;
    logic   r_phase_b, n_phase_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_phase_b <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_b <= n_phase_b;
        end
    end

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_phase_b = r_phase_b;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_phase_b  = 1'b0;
                    n_state    = S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                o_cmd.latch_size_a = r_phase_b;
                if (!r_phase_b && i_status.index_err) begin
                    n_state = S_REPORT;
                end else begin
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_status.is_root) begin
                    if (!r_phase_b) begin
                        // First root found: start the walk from the second endpoint.
                        o_cmd.root_a = 1'b1;
                        n_phase_b    = 1'b1;
                        n_state      = S_FIND_RD;
                    end else begin
                        n_state = S_MERGE;
                    end
                end else begin
                    n_state = S_FIND_HALF;
                end
            end
            S_FIND_HALF: begin
                o_cmd.half = 1'b1;
                n_state    = S_FIND_CHK;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_REPORT;
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // A new node count restarts the job with a fresh clearing pass.
        if (i_cfg_we) begin
            o_cmd.job_clear = 1'b1;
            n_state         = S_CLEAR;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> src/kufef_datapath.sv
// Union-find tables, running totals and result registers of the edge filter.
module kufef_datapath #(
    parameter int MAX_NODES = kufef_pkg::DEF_MAX_NODES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kufef_pkg::t_dp_cmd              i_cmd,
    output kufef_pkg::t_dp_status           o_status,
    input  logic [kufef_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [kufef_pkg::NODE_W-1:0]    i_node_a,
    input  logic [kufef_pkg::NODE_W-1:0]    i_node_b,
    input  logic [kufef_pkg::WEIGHT_W-1:0]  i_edge_weight,
    output logic                            o_done,
    output logic                            o_accepted,
    output logic [kufef_pkg::SUM_W-1:0]     o_total_mod,
    output logic [kufef_pkg::SUM_W-1:0]     o_doubled_total_mod,
    output logic [kufef_pkg::CFG_W-1:0]     o_components_left,
    output logic                            o_all_connected,
    output logic                            o_index_error
);
    import kufef_pkg::*;

    localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW   = $clog2(MAX_NODES + 1);
    localparam int CNTW = (SW > CFG_W) ? SW : CFG_W;
    localparam logic [CNTW-1:0] MAX_CNT  = CNTW'(MAX_NODES);
    localparam logic [NW-1:0]   LAST_IDX = NW'(MAX_NODES - 1);

    logic [NW-1:0] r_parent_mem [MAX_NODES];
    logic [SW-1:0] r_size_mem   [MAX_NODES];

    logic [CFG_W-1:0]    r_node_count;
    logic [SUM_W-1:0]    r_sum;
    logic [CNTW-1:0]     r_merges;
    logic [NW-1:0]       r_clr_addr;
    logic [NW-1:0]       r_cur;
    logic [NW-1:0]       r_node_b;
    logic [NW-1:0]       r_root_a;
    logic [NW-1:0]       r_par_q;
    logic [SW-1:0]       r_size_q;
    logic [SW-1:0]       r_size_a;
    logic [WEIGHT_W-1:0] r_wred;
    logic                r_err;
    logic                r_acc;
    logic                r_done;

    logic [CNTW-1:0]  n_eff;
    logic [CNTW-1:0]  cnt_raw;
    logic [CNTW-1:0]  left;
    logic             load_err;
    logic             same_root;
    logic             a_wins;
    logic [NW-1:0]    winner;
    logic [NW-1:0]    loser;
    logic [SUM_W:0]   sum_raw;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W:0]   dbl_raw;
    logic [SUM_W-1:0] dbl_mod;
    logic             par_we;
    logic [NW-1:0]    par_waddr;
    logic [NW-1:0]    par_wdata;
    logic [NW-1:0]    par_raddr;
    logic             size_we;
    logic [NW-1:0]    size_waddr;
    logic [SW-1:0]    size_wdata;

    // Node count zero means one node; counts above the table size saturate.
    always_comb begin
        cnt_raw = CNTW'(r_node_count);
        if (cnt_raw == '0) begin
            n_eff = CNTW'(1);
        end else if (cnt_raw > MAX_CNT) begin
            n_eff = MAX_CNT;
        end else begin
            n_eff = cnt_raw;
        end
    end

    assign load_err = (CNTW'(i_node_a) >= n_eff) || (CNTW'(i_node_b) >= n_eff);

    assign same_root = (r_root_a == r_cur);
    assign a_wins    = (r_size_a >= r_size_q);
    assign winner    = a_wins ? r_root_a : r_cur;
    assign loser     = a_wins ? r_cur : r_root_a;

    // The reduced weight is below the modulus by the time a merge needs it.
    assign sum_raw = {1'b0, r_sum} + {1'b0, r_wred[SUM_W-1:0]};
    assign n_sum   = (sum_raw >= {1'b0, MODULUS}) ? SUM_W'(sum_raw - {1'b0, MODULUS})
                                                  : sum_raw[SUM_W-1:0];
    assign dbl_raw = {r_sum, 1'b0};
    assign dbl_mod = (dbl_raw >= {1'b0, MODULUS}) ? SUM_W'(dbl_raw - {1'b0, MODULUS})
                                                  : dbl_raw[SUM_W-1:0];

    assign left = (n_eff > r_merges) ? (n_eff - r_merges) : '0;

    // During a walk the next read follows the parent just returned.
    assign par_raddr = (i_cmd.chk || i_cmd.half) ? r_par_q : r_cur;

    always_comb begin
        par_we     = 1'b0;
        par_waddr  = r_cur;
        par_wdata  = r_par_q;
        size_we    = 1'b0;
        size_waddr = winner;
        size_wdata = r_size_a + r_size_q;
        if (i_cmd.clr_step) begin
            par_we     = 1'b1;
            par_waddr  = r_clr_addr;
            par_wdata  = r_clr_addr;
            size_we    = 1'b1;
            size_waddr = r_clr_addr;
            size_wdata = SW'(1);
        end else if (i_cmd.half) begin
            // Path halving: point the current node at its grandparent.
            par_we = 1'b1;
        end else if (i_cmd.merge && !same_root) begin
            par_we    = 1'b1;
            par_waddr = loser;
            par_wdata = winner;
            size_we   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_parent_mem[par_waddr] <= par_wdata;
        end
        r_par_q <= r_parent_mem[par_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            r_size_mem[size_waddr] <= size_wdata;
        end
        r_size_q <= r_size_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_RESET;
            r_sum        <= '0;
            r_merges     <= '0;
            r_clr_addr   <= '0;
            r_done       <= 1'b0;
        end else begin
            r_done <= i_cmd.report;
            if (i_cmd.job_clear) begin
                r_node_count <= i_cfg_data;
                r_sum        <= '0;
                r_merges     <= '0;
                r_clr_addr   <= '0;
            end else begin
                if (i_cmd.clr_step) begin
                    r_clr_addr <= r_clr_addr + NW'(1);
                end
                if (i_cmd.merge && !same_root) begin
                    r_sum    <= n_sum;
                    r_merges <= r_merges + CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur    <= NW'(i_node_a);
            r_node_b <= NW'(i_node_b);
            r_wred   <= i_edge_weight;
            r_err    <= load_err;
            r_acc    <= 1'b0;
        end else begin
            if (r_wred >= {2'b00, MODULUS}) begin
                r_wred <= r_wred - {2'b00, MODULUS};
            end
            if (i_cmd.root_a) begin
                r_root_a <= r_cur;
                r_cur    <= r_node_b;
            end else if (i_cmd.half) begin
                r_cur <= r_par_q;
            end
            if (i_cmd.latch_size_a) begin
                r_size_a <= r_size_q;
            end
            if (i_cmd.merge && !same_root) begin
                r_acc <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            o_accepted          <= r_acc;
            o_total_mod         <= r_sum;
            o_doubled_total_mod <= dbl_mod;
            o_components_left   <= left[CFG_W-1:0];
            o_all_connected     <= (left == CNTW'(1));
            o_index_error       <= r_err;
        end
    end

    assign o_done             = r_done;
    assign o_status.clr_last  = (r_clr_addr == LAST_IDX);
    assign o_status.index_err = r_err;
    assign o_status.is_root   = (r_par_q == r_cur);

endmodule
